>>> hdl/thpd_pkg.sv
// ----------------------------------------------------------------------------
// Tilt drive shared definitions
// Widths, register codes, reset values and the pipeline control types that
// the tilt hysteresis drive modules use.
// ----------------------------------------------------------------------------
package thpd_pkg;

    localparam int SAMPLE_BITS_DEF   = 13;
    localparam int FULL_SCALE_MG_DEF = 1000;

    localparam int THR_W   = 10;
    localparam int DUTY_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = DUTY_W;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_MODE  = 2'd2;

    localparam logic [THR_W-1:0]  THRESHOLD_RST = 10'd50;
    localparam logic [DUTY_W-1:0] PERIOD_RST    = 16'd10000;
    localparam logic              PWM_MODE_RST  = 1'b1;

    typedef struct packed {
        logic a;
        logic b;
        logic c;
    } thpd_adv_t;

    typedef struct packed {
        logic pos;
        logic neg;
        logic sat;
    } thpd_flags_t;

endpackage

>>> hdl/thpd_hold.sv
// ----------------------------------------------------------------------------
// Tilt drive axis hold
// Keeps the last taken value of one axis and holds it while a new sample
// stays within the threshold band around it.
// ----------------------------------------------------------------------------
module thpd_hold #(
    parameter int SAMPLE_BITS = thpd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          take,
    input  logic [thpd_pkg::THR_W-1:0]    threshold,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic signed [SAMPLE_BITS-1:0] held
);

    localparam int CW = ((SAMPLE_BITS > thpd_pkg::THR_W) ? SAMPLE_BITS : thpd_pkg::THR_W) + 2;

    logic signed [SAMPLE_BITS-1:0] last_reg;
    logic signed [CW-1:0]          diff;
    logic signed [CW-1:0]          gap;
    logic signed [CW-1:0]          thr_s;

    always_comb
    begin
        diff  = CW'(sample) - CW'(last_reg);
        gap   = (diff < 0) ? -diff : diff;
        thr_s = signed'(CW'({1'b0, threshold}));
        held  = (gap < thr_s) ? last_reg : sample;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= '0;
        end
        else if (take)
        begin
            last_reg <= held;
        end
    end

endmodule

>>> hdl/thpd_scale.sv
// ----------------------------------------------------------------------------
// Tilt drive axis scaler
// Decodes the direction of one held axis value and scales the excess over
// the threshold into a duty over three pipeline stages.
// ----------------------------------------------------------------------------
module thpd_scale #(
    parameter int SAMPLE_BITS   = thpd_pkg::SAMPLE_BITS_DEF,
    parameter int FULL_SCALE_MG = thpd_pkg::FULL_SCALE_MG_DEF
) (
    input  logic                           clk,
    input  thpd_pkg::thpd_adv_t            adv,
    input  logic [thpd_pkg::THR_W-1:0]     threshold,
    input  logic [thpd_pkg::DUTY_W-1:0]    period,
    input  logic                           pwm_mode,
    input  logic signed [SAMPLE_BITS-1:0]  held,
    output logic [thpd_pkg::DUTY_W-1:0]    duty_pos,
    output logic [thpd_pkg::DUTY_W-1:0]    duty_neg
);

    localparam int CW  = ((SAMPLE_BITS > thpd_pkg::THR_W) ? SAMPLE_BITS : thpd_pkg::THR_W) + 2;
    localparam int DB  = $clog2(FULL_SCALE_MG + 1);
    localparam int XB  = thpd_pkg::DUTY_W + DB;
    localparam int SH  = XB + DB;
    localparam int MB  = XB + 2;
    localparam longint unsigned RECIP =
        ((64'd1 << SH) + longint'(FULL_SCALE_MG) - 1) / longint'(FULL_SCALE_MG);

    logic signed [CW-1:0]           v;
    logic signed [CW-1:0]           thr_s;
    logic signed [CW-1:0]           mag;
    logic signed [CW-1:0]           excess;
    logic [31:0]                    excess_w;
    thpd_pkg::thpd_flags_t          flags;

    thpd_pkg::thpd_flags_t          flags_a_reg;
    logic [DB-1:0]                  excess_a_reg;
    thpd_pkg::thpd_flags_t          flags_b_reg;
    logic [XB-1:0]                  prod_b_reg;
    logic [thpd_pkg::DUTY_W-1:0]    pos_c_reg;
    logic [thpd_pkg::DUTY_W-1:0]    neg_c_reg;

    logic [XB+MB-1:0]               scaled;
    logic [thpd_pkg::DUTY_W-1:0]    quot;
    logic [thpd_pkg::DUTY_W-1:0]    duty;

    always_comb
    begin
        v         = CW'(held);
        thr_s     = signed'(CW'({1'b0, threshold}));
        mag       = (v < 0) ? -v : v;
        excess    = mag - thr_s;
        excess_w  = 32'(unsigned'(excess));
        flags.pos = (v > thr_s);
        flags.neg = (v < -thr_s);
        flags.sat = (excess_w >= 32'(FULL_SCALE_MG));
    end

    always_comb
    begin
        scaled = (XB+MB)'(prod_b_reg) * (XB+MB)'(RECIP);
        quot   = scaled[SH +: thpd_pkg::DUTY_W];
        duty   = (!pwm_mode || flags_b_reg.sat) ? period : quot;
    end

    always_ff @(posedge clk)
    begin
        if (adv.a)
        begin
            flags_a_reg  <= flags;
            excess_a_reg <= excess[DB-1:0];
        end
        if (adv.b)
        begin
            flags_b_reg <= flags_a_reg;
            prod_b_reg  <= XB'(period) * XB'(excess_a_reg);
        end
        if (adv.c)
        begin
            pos_c_reg <= flags_b_reg.pos ? duty : '0;
            neg_c_reg <= flags_b_reg.neg ? duty : '0;
        end
    end

    assign duty_pos = pos_c_reg;
    assign duty_neg = neg_c_reg;

endmodule

>>> hdl/tilt_hysteresis_pwm_drive_core.sv
// A result passes the stage a, b and c registers after its sample transfer.
// Throughput: one sample per cycle while not stalled; the hold compare loops
// through the stored axis values and duty scaling runs in two further stages.
// Reset clears all stage valids, the stored axis values to zero and the
// registers to threshold 50, period 10000 and proportional mode.
// ----------------------------------------------------------------------------
// Tilt hysteresis PWM drive
// Holds each accelerometer axis within a threshold band and turns the held
// X and Y tilt into duties for four direction channels.
// ----------------------------------------------------------------------------
module tilt_hysteresis_pwm_drive_core #(
    parameter int SAMPLE_BITS   = thpd_pkg::SAMPLE_BITS_DEF,
    parameter int FULL_SCALE_MG = thpd_pkg::FULL_SCALE_MG_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [thpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [thpd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [SAMPLE_BITS-1:0]     accel_x,
    input  logic signed [SAMPLE_BITS-1:0]     accel_y,
    input  logic signed [SAMPLE_BITS-1:0]     accel_z,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [thpd_pkg::DUTY_W-1:0]       duty_ch1,
    output logic [thpd_pkg::DUTY_W-1:0]       duty_ch2,
    output logic [thpd_pkg::DUTY_W-1:0]       duty_ch3,
    output logic [thpd_pkg::DUTY_W-1:0]       duty_ch4,
    output logic signed [SAMPLE_BITS-1:0]     held_x,
    output logic signed [SAMPLE_BITS-1:0]     held_y,
    output logic signed [SAMPLE_BITS-1:0]     held_z
);

    logic [thpd_pkg::THR_W-1:0]     threshold_reg;
    logic [thpd_pkg::DUTY_W-1:0]    period_reg;
    logic                           pwm_mode_reg;

    logic                           va_reg;
    logic                           vb_reg;
    logic                           vc_reg;
    logic                           rdy_a;
    logic                           rdy_b;
    logic                           rdy_c;
    thpd_pkg::thpd_adv_t            adv;

    logic signed [SAMPLE_BITS-1:0]  hx;
    logic signed [SAMPLE_BITS-1:0]  hy;
    logic signed [SAMPLE_BITS-1:0]  hz;
    logic signed [SAMPLE_BITS-1:0]  hx_a_reg, hy_a_reg, hz_a_reg;
    logic signed [SAMPLE_BITS-1:0]  hx_b_reg, hy_b_reg, hz_b_reg;
    logic signed [SAMPLE_BITS-1:0]  hx_c_reg, hy_c_reg, hz_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= thpd_pkg::THRESHOLD_RST;
            period_reg    <= thpd_pkg::PERIOD_RST;
            pwm_mode_reg  <= thpd_pkg::PWM_MODE_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                thpd_pkg::REG_THRESHOLD: threshold_reg <= cfg_data[thpd_pkg::THR_W-1:0];
                thpd_pkg::REG_PERIOD:    period_reg    <= cfg_data[thpd_pkg::DUTY_W-1:0];
                thpd_pkg::REG_PWM_MODE:  pwm_mode_reg  <= cfg_data[0];
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        rdy_c    = !vc_reg || !out_stall;
        rdy_b    = !vb_reg || rdy_c;
        rdy_a    = !va_reg || rdy_b;
        in_stall = !rdy_a;
        adv.a    = in_valid && rdy_a;
        adv.b    = va_reg && rdy_b;
        adv.c    = vb_reg && rdy_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            if (adv.a)
                va_reg <= 1'b1;
            else if (adv.b)
                va_reg <= 1'b0;
            if (adv.b)
                vb_reg <= 1'b1;
            else if (adv.c)
                vb_reg <= 1'b0;
            if (adv.c)
                vc_reg <= 1'b1;
            else if (!out_stall)
                vc_reg <= 1'b0;
        end
    end

    thpd_hold #(.SAMPLE_BITS(SAMPLE_BITS)) u_hold_x (
        .clk(clk), .rst_n(rst_n), .take(adv.a), .threshold(threshold_reg),
        .sample(accel_x), .held(hx)
    );

    thpd_hold #(.SAMPLE_BITS(SAMPLE_BITS)) u_hold_y (
        .clk(clk), .rst_n(rst_n), .take(adv.a), .threshold(threshold_reg),
        .sample(accel_y), .held(hy)
    );

    thpd_hold #(.SAMPLE_BITS(SAMPLE_BITS)) u_hold_z (
        .clk(clk), .rst_n(rst_n), .take(adv.a), .threshold(threshold_reg),
        .sample(accel_z), .held(hz)
    );

    thpd_scale #(.SAMPLE_BITS(SAMPLE_BITS), .FULL_SCALE_MG(FULL_SCALE_MG)) u_scale_x (
        .clk(clk), .adv(adv), .threshold(threshold_reg), .period(period_reg),
        .pwm_mode(pwm_mode_reg), .held(hx), .duty_pos(duty_ch3), .duty_neg(duty_ch1)
    );

    thpd_scale #(.SAMPLE_BITS(SAMPLE_BITS), .FULL_SCALE_MG(FULL_SCALE_MG)) u_scale_y (
        .clk(clk), .adv(adv), .threshold(threshold_reg), .period(period_reg),
        .pwm_mode(pwm_mode_reg), .held(hy), .duty_pos(duty_ch2), .duty_neg(duty_ch4)
    );

    always_ff @(posedge clk)
    begin
        if (adv.a)
        begin
            hx_a_reg <= hx;
            hy_a_reg <= hy;
            hz_a_reg <= hz;
        end
        if (adv.b)
        begin
            hx_b_reg <= hx_a_reg;
            hy_b_reg <= hy_a_reg;
            hz_b_reg <= hz_a_reg;
        end
        if (adv.c)
        begin
            hx_c_reg <= hx_b_reg;
            hy_c_reg <= hy_b_reg;
            hz_c_reg <= hz_b_reg;
        end
    end

    assign out_valid = vc_reg;
    assign held_x    = hx_c_reg;
    assign held_y    = hy_c_reg;
    assign held_z    = hz_c_reg;

endmodule

>>> hdl/thpd_checker.sv
// ----------------------------------------------------------------------------
// Tilt drive port checker
// Watches the ports of the tilt hysteresis drive for reset, channel
// exclusivity, stall behavior and pipeline latency.
// ----------------------------------------------------------------------------
module thpd_checker #(
    parameter int SAMPLE_BITS = thpd_pkg::SAMPLE_BITS_DEF
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [thpd_pkg::DUTY_W-1:0]    duty_ch1,
    input logic [thpd_pkg::DUTY_W-1:0]    duty_ch2,
    input logic [thpd_pkg::DUTY_W-1:0]    duty_ch3,
    input logic [thpd_pkg::DUTY_W-1:0]    duty_ch4,
    input logic signed [SAMPLE_BITS-1:0]  held_x
);

    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("Output valid seen during reset.");

    a_x_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (duty_ch1 == '0 || duty_ch3 == '0))
        else $error("Both X direction channels are driven.");

    a_y_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (duty_ch2 == '0 || duty_ch4 == '0))
        else $error("Both Y direction channels are driven.");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(duty_ch1) && $stable(duty_ch3)
            && $stable(held_x))
        else $error("Stalled result changed.");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall ##1 !out_stall ##1 !out_stall) |=> out_valid)
        else $error("Transfer did not reach the output in three cycles.");

endmodule

bind tilt_hysteresis_pwm_drive_core thpd_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_thpd_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .duty_ch1(duty_ch1),
    .duty_ch2(duty_ch2),
    .duty_ch3(duty_ch3),
    .duty_ch4(duty_ch4),
    .held_x(held_x)
);

>>> test/tb_tilt_hysteresis_pwm_drive_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tilt hysteresis PWM drive testbench
// Sends accelerometer samples through the valid/stall input channel, predicts
// the held axis values and the four channel duties for every accepted
// transfer, and compares each accepted result transfer field by field. The run
// steps through several register settings and idle patterns on both channels.
// ----------------------------------------------------------------------------
module tb_tilt_hysteresis_pwm_drive_core;

    localparam int SB = thpd_pkg::SAMPLE_BITS_DEF;
    localparam int CFG_W = thpd_pkg::CFG_DATA_W;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 130;
    localparam int SAMPLE_MAX = (1 << (SB - 1)) - 1;
    localparam int SAMPLE_MIN = -(1 << (SB - 1));
    localparam logic [thpd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [thpd_pkg::DUTY_W-1:0] ch1;
        logic [thpd_pkg::DUTY_W-1:0] ch2;
        logic [thpd_pkg::DUTY_W-1:0] ch3;
        logic [thpd_pkg::DUTY_W-1:0] ch4;
        logic signed [SB-1:0]        hx;
        logic signed [SB-1:0]        hy;
        logic signed [SB-1:0]        hz;
    } drive_result_t;

    class tilt_drive_scoreboard;
        logic [thpd_pkg::THR_W-1:0]  thr;
        logic [thpd_pkg::DUTY_W-1:0] per;
        logic                        prop_mode;
        logic signed [SB-1:0]        last_x;
        logic signed [SB-1:0]        last_y;
        logic signed [SB-1:0]        last_z;
        drive_result_t               pending_q[$];
        int                          errors;

        function new();
            thr = thpd_pkg::THRESHOLD_RST;
            per = thpd_pkg::PERIOD_RST;
            prop_mode = thpd_pkg::PWM_MODE_RST;
            last_x = '0;
            last_y = '0;
            last_z = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [thpd_pkg::CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                thpd_pkg::REG_THRESHOLD: thr = data[thpd_pkg::THR_W-1:0];
                thpd_pkg::REG_PERIOD:    per = data[thpd_pkg::DUTY_W-1:0];
                thpd_pkg::REG_PWM_MODE:  prop_mode = data[0];
                default: ;
            endcase
        endfunction

        function logic signed [SB-1:0] hold_axis(logic signed [SB-1:0] s,
                                                 logic signed [SB-1:0] prev);
            int d;
            d = int'(s) - int'(prev);
            if (d < 0)
                d = -d;
            if (d < int'(thr))
                return prev;
            return s;
        endfunction

        function logic [thpd_pkg::DUTY_W-1:0] duty_of(int mag);
            longint q;
            if (!prop_mode)
                return per;
            q = (longint'(per) * longint'(mag - int'(thr))) / thpd_pkg::FULL_SCALE_MG_DEF;
            if (q > longint'(per))
                q = longint'(per);
            return q[thpd_pkg::DUTY_W-1:0];
        endfunction

        function void drive_axis(int v, output logic [thpd_pkg::DUTY_W-1:0] pos,
                                 output logic [thpd_pkg::DUTY_W-1:0] neg);
            pos = '0;
            neg = '0;
            if (v > int'(thr))
                pos = duty_of(v);
            else if (v < -int'(thr))
                neg = duty_of(-v);
        endfunction

        function void note_sample(logic signed [SB-1:0] x, logic signed [SB-1:0] y,
                                  logic signed [SB-1:0] z);
            drive_result_t r;
            last_x = hold_axis(x, last_x);
            last_y = hold_axis(y, last_y);
            last_z = hold_axis(z, last_z);
            r.hx = last_x;
            r.hy = last_y;
            r.hz = last_z;
            drive_axis(int'(last_x), r.ch3, r.ch1);
            drive_axis(int'(last_y), r.ch2, r.ch4);
            pending_q.push_back(r);
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("mismatch on %s: got %0d, expected %0d", what, got, want);
            errors++;
        endtask

        task check_result(drive_result_t got);
            drive_result_t want;
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected result transfer", 1, 0);
                return;
            end
            want = pending_q.pop_front();
            if (got.ch1 !== want.ch1) report_mismatch("duty_ch1", got.ch1, want.ch1);
            if (got.ch2 !== want.ch2) report_mismatch("duty_ch2", got.ch2, want.ch2);
            if (got.ch3 !== want.ch3) report_mismatch("duty_ch3", got.ch3, want.ch3);
            if (got.ch4 !== want.ch4) report_mismatch("duty_ch4", got.ch4, want.ch4);
            if (got.hx !== want.hx) report_mismatch("held_x", got.hx, want.hx);
            if (got.hy !== want.hy) report_mismatch("held_y", got.hy, want.hy);
            if (got.hz !== want.hz) report_mismatch("held_z", got.hz, want.hz);
        endtask
    endclass

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_wr_en;
    logic [thpd_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]                  cfg_data;
    logic                              in_valid;
    logic                              in_stall;
    logic signed [SB-1:0]              accel_x;
    logic signed [SB-1:0]              accel_y;
    logic signed [SB-1:0]              accel_z;
    logic                              out_valid;
    logic                              out_stall;
    logic [thpd_pkg::DUTY_W-1:0]       duty_ch1;
    logic [thpd_pkg::DUTY_W-1:0]       duty_ch2;
    logic [thpd_pkg::DUTY_W-1:0]       duty_ch3;
    logic [thpd_pkg::DUTY_W-1:0]       duty_ch4;
    logic signed [SB-1:0]              held_x;
    logic signed [SB-1:0]              held_y;
    logic signed [SB-1:0]              held_z;

    tilt_drive_scoreboard duty_board;
    int send_pct;
    int stall_pct;
    int cycle_count = 0;

    tilt_hysteresis_pwm_drive_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .accel_x   (accel_x),
        .accel_y   (accel_y),
        .accel_z   (accel_z),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .duty_ch1  (duty_ch1),
        .duty_ch2  (duty_ch2),
        .duty_ch3  (duty_ch3),
        .duty_ch4  (duty_ch4),
        .held_x    (held_x),
        .held_y    (held_y),
        .held_z    (held_z)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_tilt_hysteresis_pwm_drive_core: errors");
            $finish;
        end
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            duty_board.check_result({duty_ch1, duty_ch2, duty_ch3, duty_ch4,
                                     held_x, held_y, held_z});
    end

    function automatic logic signed [SB-1:0] clamp_sample(int v);
        if (v > SAMPLE_MAX)
            v = SAMPLE_MAX;
        if (v < SAMPLE_MIN)
            v = SAMPLE_MIN;
        return v[SB-1:0];
    endfunction

    function automatic logic signed [SB-1:0] pick_sample(logic signed [SB-1:0] held);
        int kind;
        int t;
        int sgn;
        logic [SB-1:0] raw;
        kind = $urandom_range(0, 9);
        t = int'(duty_board.thr);
        sgn = $urandom_range(0, 1) ? 1 : -1;
        raw = SB'($urandom_range(0, (1 << SB) - 1));
        case (kind)
            0, 1, 2: return raw;
            3, 4:    return clamp_sample(int'(held) + sgn * int'($urandom_range(0, 2 * t + 4)));
            5, 6:    return clamp_sample(int'(held) + sgn * (t + int'($urandom_range(0, 4)) - 2));
            7, 8:    return clamp_sample(sgn * (t + int'($urandom_range(0, 2000)) - 20));
            default:
            begin
                case ($urandom_range(0, 2))
                    0: return SB'(SAMPLE_MAX);
                    1: return SB'(SAMPLE_MIN);
                    default: return '0;
                endcase
            end
        endcase
    endfunction

    task automatic set_idle(int mode);
        case (mode)
            1: begin send_pct = 48; stall_pct = 0;  end
            2: begin send_pct = 0;  stall_pct = 48; end
            3: begin send_pct = 26; stall_pct = 26; end
            default: begin send_pct = 0; stall_pct = 0; end
        endcase
    endtask

    // Called just after a falling edge; returns just after a falling edge.
    task automatic send_sample(int x, int y, int z);
        while ($urandom_range(0, 99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        accel_x <= clamp_sample(x);
        accel_y <= clamp_sample(y);
        accel_z <= clamp_sample(z);
        do
            @(posedge clk);
        while (in_stall);
        duty_board.note_sample(clamp_sample(x), clamp_sample(y), clamp_sample(z));
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (duty_board.pending_q.size() != 0)
            @(posedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic cfg_write(logic [thpd_pkg::CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        duty_board.write_reg(idx, data);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apply_setting(int thr, int per, int mode);
        logic [CFG_W-1:0] junk;
        junk = CFG_W'($urandom_range(0, 65535));
        cfg_write(thpd_pkg::REG_THRESHOLD,
                  {junk[CFG_W-1:thpd_pkg::THR_W], thr[thpd_pkg::THR_W-1:0]});
        cfg_write(thpd_pkg::REG_PERIOD, per[thpd_pkg::DUTY_W-1:0]);
        cfg_write(thpd_pkg::REG_PWM_MODE, {junk[CFG_W-2:0], mode[0]});
    endtask

    int dir_x[18] = '{0, 49, 50, 100, 1050, 1051, 4095, -4096, 0, -51, -60, -101,
                      4095, -4096, 1, 2000, -2000, 0};
    int dir_y[18] = '{0, -49, -50, -100, -1050, -1051, -4096, 4095, 0, 51, 60, 101,
                      4095, -4096, -1, -2000, 2000, 0};
    int dir_z[18] = '{0, 49, 50, 0, 4095, 4094, -4096, 4095, 0, 3000, 3010, -3000,
                      -4096, 4095, 0, 10, -10, 0};
    int set_thr[8]  = '{0, 1000, 1023, 50, 200, 10, 0, 50};
    int set_per[8]  = '{10000, 65535, 1000, 0, 65535, 4096, 0, 10000};
    int set_mode[8] = '{1, 1, 1, 1, 0, 1, 0, 1};

    initial
    begin
        logic signed [SB-1:0] sx;
        logic signed [SB-1:0] sy;
        logic signed [SB-1:0] sz;
        duty_board = new();
        set_idle(0);
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        accel_x = '0;
        accel_y = '0;
        accel_z = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < 18; i++)
            send_sample(dir_x[i], dir_y[i], dir_z[i]);
        drain_results();

        for (int ph = 0; ph < 8; ph++)
        begin
            set_idle(ph % 4);
            if (ph == 6)
                apply_setting($urandom_range(0, 1023), $urandom_range(0, 65535),
                              $urandom_range(0, 1));
            else
                apply_setting(set_thr[ph], set_per[ph], set_mode[ph]);
            if (ph == 3)
                cfg_write(REG_UNUSED, CFG_W'($urandom_range(0, 65535)));
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                sx = pick_sample(duty_board.last_x);
                sy = pick_sample(duty_board.last_y);
                sz = pick_sample(duty_board.last_z);
                send_sample(int'(sx), int'(sy), int'(sz));
            end
            drain_results();
        end

        repeat (10) @(negedge clk);
        if (duty_board.errors == 0)
            $display("tb_tilt_hysteresis_pwm_drive_core: clean");
        else
            $display("tb_tilt_hysteresis_pwm_drive_core: errors");
        $finish;
    end

endmodule

>>> sim.f
hdl/thpd_pkg.sv
hdl/thpd_hold.sv
hdl/thpd_scale.sv
hdl/tilt_hysteresis_pwm_drive_core.sv
hdl/thpd_checker.sv
test/tb_tilt_hysteresis_pwm_drive_core.sv
